@@ rtl/horizontal_gaze_estimator_assert.svh @@
// Assertion macros used by the RTL of the gaze estimator.
`ifndef HORIZONTAL_GAZE_ESTIMATOR_ASSERT_SVH
`define HORIZONTAL_GAZE_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HGE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HGE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hge_pkg.sv @@
`default_nettype none
package hge_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int COORD_BITS    = 12;
	localparam int CURVE_ENTRIES = 257;
	localparam int SEG_COUNT     = CURVE_ENTRIES - 1;

	localparam longint unsigned LN2_Q32 = 64'd2977044472;
	localparam longint unsigned ONE_Q32 = 64'd4294967296;

	typedef enum logic [2:0] {
		CFG_SCREEN_WIDTH = 3'd0,
		CFG_LEFT_MIN     = 3'd1,
		CFG_LEFT_MAX     = 3'd2,
		CFG_LEFT_RANGE   = 3'd3,
		CFG_RIGHT_MIN    = 3'd4,
		CFG_RIGHT_MAX    = 3'd5,
		CFG_RIGHT_RANGE  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        left_present;
		logic [11:0] left_x;
		logic        right_present;
		logic [11:0] right_x;
		logic [11:0] face_width;
	} in_word_t;

	typedef struct packed {
		logic        valid_res;
		logic [1:0]  zone;
		logic [15:0] gaze_ratio;
		logic [13:0] displacement;
	} out_word_t;

	typedef logic [16:0] curve_tab_t [0:CURVE_ENTRIES-1];

	// Shift-subtract quotient, evaluated while the curve table is built
	function automatic longint unsigned long_quot(longint unsigned num,
			longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((num >> b) & 64'd1);
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// e^y - 1, Q32
	function automatic longint unsigned expm1_q32(longint unsigned y);
		longint unsigned term;
		longint unsigned sum;
		term = y;
		sum  = y;
		for (int k = 2; k < 26; k++) begin
			term = long_quot((term * y) >> 32, longint'(k));
			if (term == 0) break;
			sum += term;
		end
		return sum;
	endfunction

	// u^0.7, Q32
	function automatic longint unsigned pow07_q32(longint unsigned u);
		longint unsigned m;
		longint unsigned e;
		longint unsigned f;
		longint unsigned a;
		longint unsigned v;
		longint unsigned n;
		longint unsigned r;
		longint unsigned w;
		longint unsigned p;
		m = u;
		e = 0;
		f = 0;
		if (u == 0) return 0;
		if (u >= ONE_Q32) return ONE_Q32;
		while (m < ONE_Q32) begin
			m = m << 1;
			e++;
		end
		m = m >> 2;
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			f = f << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				f = f | 64'd1;
			end
		end
		a = (e << 30) - f;
		v = a * 7 / 10;
		n = v >> 30;
		r = v & ((64'd1 << 30) - 64'd1);
		w = ((64'd1 << 30) - r) << 2;
		p = ONE_Q32 + expm1_q32((w * LN2_Q32) >> 32);
		if (n + 1 >= 63) return 0;
		return p >> (n + 1);
	endfunction

	// (2^t - 1)^0.7 over t in [0,1], Q1.16
	function automatic curve_tab_t build_curve();
		curve_tab_t tab;
		longint unsigned t;
		longint unsigned u;
		longint unsigned y;
		longint unsigned ent;
		for (int i = 0; i < CURVE_ENTRIES; i++) begin
			t = (longint'(i) << 32) / SEG_COUNT;
			u = expm1_q32((t * LN2_Q32) >> 32);
			if (u > ONE_Q32) u = ONE_Q32;
			y = pow07_q32(u);
			ent = (y + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
			if (ent > (64'd1 << FRAC_BITS)) ent = 64'd1 << FRAC_BITS;
			tab[i] = ent[16:0];
		end
		return tab;
	endfunction

	localparam curve_tab_t CURVE = build_curve();

endpackage
`default_nettype wire

@@ rtl/hge_in_if.sv @@
`default_nettype none
interface hge_in_if;
	logic             valid;
	logic             ready;
	hge_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/hge_out_if.sv @@
`default_nettype none
interface hge_out_if;
	logic              valid;
	logic              ready;
	hge_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/horizontal_gaze_estimator.sv @@
// Throughput: one word per cycle while the output word is not held; every stage is registered and advances together.
// Cost sits in three restoring dividers that retire one quotient bit per stage.
// Reset (arst_n low, asynchronous): pipeline empties, configuration returns to
// screen 1920 and the calibrated left/right distance ranges.
`default_nettype none
`include "horizontal_gaze_estimator_assert.svh"
module horizontal_gaze_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hge_in_if.sink           in_ch,
	hge_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata
);

	// Stage map
	localparam int ST_A_LAST = 16;  // pupil distance quotient bits
	localparam int ST_CLAMP  = 17;
	localparam int ST_MIRROR = 18;
	localparam int ST_B_TOP  = 19;
	localparam int ST_B_LAST = 43;  // curve position quotient bits
	localparam int ST_LOOKUP = 44;
	localparam int ST_MUL    = 45;
	localparam int ST_CV     = 46;
	localparam int ST_MAG    = 47;
	localparam int ST_EYE    = 48;
	localparam int ST_SUM    = 49;
	localparam int ST_ACC    = 50;
	localparam int ST_ZONE   = 51;
	localparam int N         = 67;  // ratio quotient bits end here; output register

	typedef struct packed {
		logic [1:0]        pres;
		logic [1:0][13:0]  rem1;
		logic [1:0][12:0]  den1;
		logic [1:0][15:0]  q1;
		logic [1:0]        sat;
		logic [1:0][15:0]  d;
		logic [1:0][15:0]  rg;
		logic [1:0]        right;
		logic [1:0][16:0]  dist2;
		logic [1:0][15:0]  rem2;
		logic [1:0][24:0]  q2;
		logic [1:0][16:0]  lo;
		logic [1:0][16:0]  diff;
		logic [1:0][15:0]  fr;
		logic [1:0][32:0]  prod;
		logic [1:0][16:0]  cv;
		logic [1:0][29:0]  mag;
		logic [1:0][30:0]  g2;
		logic [14:0]       acc1;
		logic [31:0]       s;
		logic [31:0]       gsum;
		logic [1:0]        n;
		logic [14:0]       acc;
		logic [15:0]       den3;
		logic [41:0]       p1000;
		logic [24:0]       c333;
		logic [1:0]        zone;
		logic [13:0]       disp;
		logic [15:0]       rem3;
		logic [15:0]       q3;
	} stage_t;

	// Configuration registers
	logic [13:0] sw_q;
	logic [15:0] lmin_q, lmax_q, lrng_q, rmin_q, rmax_q, rrng_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= 14'd1920;
			lmin_q <= 16'd11829;
			lmax_q <= 16'd15257;
			lrng_q <= 16'd3428;
			rmin_q <= 16'd10053;
			rmax_q <= 16'd12452;
			rrng_q <= 16'd2399;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hge_pkg::CFG_SCREEN_WIDTH: sw_q   <= cfg_wdata[13:0];
				hge_pkg::CFG_LEFT_MIN:     lmin_q <= cfg_wdata;
				hge_pkg::CFG_LEFT_MAX:     lmax_q <= cfg_wdata;
				hge_pkg::CFG_LEFT_RANGE:   lrng_q <= cfg_wdata;
				hge_pkg::CFG_RIGHT_MIN:    rmin_q <= cfg_wdata;
				hge_pkg::CFG_RIGHT_MAX:    rmax_q <= cfg_wdata;
				hge_pkg::CFG_RIGHT_RANGE:  rrng_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Eye 0 is left (mirrored), eye 1 is right
	logic [1:0][15:0] mn_c, mx_c, rg_c;
	logic [13:0]      sw_eff;
	logic [12:0]      swm1;
	assign mn_c   = {rmin_q, lmin_q};
	assign mx_c   = {rmax_q, lmax_q};
	assign rg_c   = {rrng_q, lrng_q};
	assign sw_eff = (sw_q == 14'd0) ? 14'd1 : sw_q;
	assign swm1   = 13'(sw_eff - 14'd1);

	stage_t     pipe [0:N];
	stage_t     nxt0;
	stage_t     nxt  [1:N];
	logic [N:0] vld;
	logic       adv;

	// The whole pipe advances unless the output word is held
	assign adv          = !vld[N] || out_ch.ready;
	assign in_ch.ready  = adv;

	// Stage 0: distance numerator |2x+1-fw| and divisor 2*fw
	always_comb begin
		logic [11:0] fw;
		logic [12:0] x2;
		logic [13:0] num;
		fw = '0;
		x2 = '0;
		num = '0;
		nxt0         = '0;
		nxt0.pres    = {in_ch.data.right_present, in_ch.data.left_present};
		fw = (in_ch.data.face_width == 12'd0) ? 12'd1 : in_ch.data.face_width;
		for (int e = 0; e < 2; e++) begin
			x2 = (e == 0) ? {in_ch.data.left_x, 1'b1} : {in_ch.data.right_x, 1'b1};
			num = ({1'b0, x2} >= {2'b0, fw}) ? 14'({1'b0, x2} - {2'b0, fw})
			                                  : 14'({2'b0, fw} - {1'b0, x2});
			nxt0.den1[e] = {fw, 1'b0};
			nxt0.sat[e]  = (num >= {1'b0, fw, 1'b0});
			nxt0.rem1[e] = nxt0.sat[e] ? 14'd0 : num;
			nxt0.q1[e]   = '0;
		end
	end

	// Stages 1..N
	always_comb begin
		logic [14:0] r1;
		logic [16:0] dq;
		logic [15:0] d2;
		logic [16:0] twod;
		logic [16:0] r2;
		logic [24:0] pos;
		logic [8:0]  idx;
		logic [28:0] base;
		logic [12:0] m;
		logic [31:0] sacc;
		logic [31:0] term;
		logic [31:0] mg;
		logic [15:0] dd;
		logic [15:0] hs;
		logic [16:0] r3;
		for (int k = 1; k <= N; k++) begin
			r1 = '0; dq = '0; d2 = '0; twod = '0; r2 = '0; pos = '0; idx = '0;
			base = '0; m = '0; sacc = '0; term = '0; mg = '0; dd = '0; hs = '0; r3 = '0;
			nxt[k] = pipe[k-1];
			for (int e = 0; e < 2; e++) begin
				if (k <= ST_A_LAST) begin
					r1 = {pipe[k-1].rem1[e], 1'b0};
					if (r1 >= {2'b0, pipe[k-1].den1[e]}) begin
						nxt[k].rem1[e] = 14'(r1 - {2'b0, pipe[k-1].den1[e]});
						nxt[k].q1[e]   = {pipe[k-1].q1[e][14:0], 1'b1};
					end else begin
						nxt[k].rem1[e] = r1[13:0];
						nxt[k].q1[e]   = {pipe[k-1].q1[e][14:0], 1'b0};
					end
				end
				if (k == ST_CLAMP) begin
					// clamp to [min,max], max last; offset by min, limit to range
					dq = pipe[k-1].sat[e] ? 17'h10000 : {1'b0, pipe[k-1].q1[e]};
					if (dq < {1'b0, mn_c[e]}) dq = {1'b0, mn_c[e]};
					if (dq > {1'b0, mx_c[e]}) dq = {1'b0, mx_c[e]};
					d2 = (dq[15:0] >= mn_c[e]) ? 16'(dq[15:0] - mn_c[e]) : 16'd0;
					if (d2 > rg_c[e]) d2 = rg_c[e];
					nxt[k].d[e]  = d2;
					nxt[k].rg[e] = rg_c[e];
				end
				if (k == ST_MIRROR) begin
					d2   = (e == 0) ? 16'(pipe[k-1].rg[e] - pipe[k-1].d[e]) : pipe[k-1].d[e];
					twod = {d2, 1'b0};
					nxt[k].right[e] = (twod >= {1'b0, pipe[k-1].rg[e]});
					nxt[k].dist2[e] = nxt[k].right[e] ? 17'(twod - {1'b0, pipe[k-1].rg[e]})
					                                  : 17'({1'b0, pipe[k-1].rg[e]} - twod);
				end
				if (k == ST_B_TOP) begin
					if (pipe[k-1].dist2[e] >= {1'b0, pipe[k-1].rg[e]}) begin
						nxt[k].rem2[e] = 16'(pipe[k-1].dist2[e] - {1'b0, pipe[k-1].rg[e]});
						nxt[k].q2[e]   = 25'd1;
					end else begin
						nxt[k].rem2[e] = pipe[k-1].dist2[e][15:0];
						nxt[k].q2[e]   = 25'd0;
					end
				end
				if (k > ST_B_TOP && k <= ST_B_LAST) begin
					r2 = {pipe[k-1].rem2[e], 1'b0};
					if (r2 >= {1'b0, pipe[k-1].rg[e]}) begin
						nxt[k].rem2[e] = 16'(r2 - {1'b0, pipe[k-1].rg[e]});
						nxt[k].q2[e]   = {pipe[k-1].q2[e][23:0], 1'b1};
					end else begin
						nxt[k].rem2[e] = r2[15:0];
						nxt[k].q2[e]   = {pipe[k-1].q2[e][23:0], 1'b0};
					end
				end
				if (k == ST_LOOKUP) begin
					// zero range pins the curve position to its start
					pos = (pipe[k-1].rg[e] == 16'd0) ? 25'd0 : pipe[k-1].q2[e];
					idx = pos[24:16];
					nxt[k].fr[e] = pos[15:0];
					if (idx[8]) begin
						nxt[k].lo[e]   = hge_pkg::CURVE[hge_pkg::SEG_COUNT];
						nxt[k].diff[e] = '0;
					end else begin
						nxt[k].lo[e]   = hge_pkg::CURVE[idx];
						nxt[k].diff[e] = 17'(hge_pkg::CURVE[9'(idx + 9'd1)] - hge_pkg::CURVE[idx]);
					end
				end
				if (k == ST_MUL) nxt[k].prod[e] = pipe[k-1].diff[e] * pipe[k-1].fr[e];
				if (k == ST_CV)  nxt[k].cv[e] = 17'(pipe[k-1].lo[e] + pipe[k-1].prod[e][32:16]);
				if (k == ST_MAG) nxt[k].mag[e] = swm1 * pipe[k-1].cv[e];
				if (k == ST_EYE) begin
					base = {swm1, 16'b0};
					nxt[k].g2[e] = pipe[k-1].right[e] ? 31'({2'b0, base} + {1'b0, pipe[k-1].mag[e]})
					                                  : 31'({2'b0, base} - {1'b0, pipe[k-1].mag[e]});
				end
			end
			if (k == ST_EYE) begin
				// left eye contribution, truncated toward zero
				m = pipe[k-1].mag[0][29:17];
				if (!pipe[k-1].pres[0])     nxt[k].acc1 = '0;
				else if (pipe[k-1].right[0]) nxt[k].acc1 = {2'b0, m};
				else                         nxt[k].acc1 = 15'(-{2'b0, m});
			end
			if (k == ST_SUM) begin
				sacc = 32'(signed'(pipe[k-1].acc1)) << 17;
				if (!pipe[k-1].pres[1])      term = '0;
				else if (pipe[k-1].right[1]) term = {2'b0, pipe[k-1].mag[1]};
				else                         term = 32'(-{2'b0, pipe[k-1].mag[1]});
				nxt[k].s    = sacc + term;
				nxt[k].gsum = (pipe[k-1].pres[0] ? {1'b0, pipe[k-1].g2[0]} : 32'd0)
				            + (pipe[k-1].pres[1] ? {1'b0, pipe[k-1].g2[1]} : 32'd0);
				nxt[k].n    = {1'b0, pipe[k-1].pres[0]} + {1'b0, pipe[k-1].pres[1]};
			end
			if (k == ST_ACC) begin
				mg = pipe[k-1].s[31] ? 32'(-pipe[k-1].s) : pipe[k-1].s;
				nxt[k].acc = pipe[k-1].s[31] ? 15'(-(mg >> 17)) : 15'(mg >> 17);
				dd = (pipe[k-1].n == 2'd2) ? {sw_eff, 2'b0} : {1'b0, sw_eff, 1'b0};
				nxt[k].den3  = dd;
				nxt[k].p1000 = pipe[k-1].gsum * 10'd1000;
				nxt[k].c333  = dd * 9'd333;
			end
			if (k == ST_ZONE) begin
				if (pipe[k-1].n == 2'd0) begin
					nxt[k].zone = 2'd1;
				end else begin
					nxt[k].zone = 2'd1
					            + 2'(pipe[k-1].p1000 >= {1'b0, pipe[k-1].c333, 16'b0})
					            + 2'(pipe[k-1].p1000 >= {pipe[k-1].c333, 17'b0});
				end
				hs = {pipe[k-1].acc[14], pipe[k-1].acc} + {15'b0, pipe[k-1].acc[14]};
				nxt[k].disp = (pipe[k-1].n == 2'd2) ? hs[14:1] : pipe[k-1].acc[13:0];
				nxt[k].rem3 = pipe[k-1].gsum[31:16];
				nxt[k].q3   = pipe[k-1].gsum[15:0];
			end
			if (k > ST_ZONE) begin
				// shift in dividend bits, shift out quotient bits
				r3 = {pipe[k-1].rem3, pipe[k-1].q3[15]};
				if (r3 >= {1'b0, pipe[k-1].den3}) begin
					nxt[k].rem3 = 16'(r3 - {1'b0, pipe[k-1].den3});
					nxt[k].q3   = {pipe[k-1].q3[14:0], 1'b1};
				end else begin
					nxt[k].rem3 = r3[15:0];
					nxt[k].q3   = {pipe[k-1].q3[14:0], 1'b0};
				end
			end
		end
	end

	// Valid bits: cleared at reset, advance with the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[N-1:0], in_ch.valid};
		end
	end

	// Payload: no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			pipe[0] <= nxt0;
			for (int k = 1; k <= N; k++) pipe[k] <= nxt[k];
		end
	end

	assign out_ch.valid             = vld[N];
	assign out_ch.data.valid_res    = (pipe[N].n != 2'd0);
	assign out_ch.data.zone         = pipe[N].zone;
	assign out_ch.data.gaze_ratio   = (pipe[N].n != 2'd0) ? pipe[N].q3 : 16'd0;
	assign out_ch.data.displacement = pipe[N].disp;

	`HGE_ASSERT_NXT(a_stall_freezes, vld[N] && !out_ch.ready, $stable(vld), "pipe moved while output held")
	`HGE_ASSERT_IMP(a_zone_range, vld[N], pipe[N].zone != 2'd0, "zone out of range")
	`HGE_ASSERT_IMP(a_no_pupil, vld[N] && pipe[N].n == 2'd0, pipe[N].zone == 2'd1 && pipe[N].disp == 14'd0, "no-pupil word not neutral")
	`HGE_ASSERT_IMP(a_ratio_bound, vld[ST_ZONE] && pipe[ST_ZONE].n != 2'd0, pipe[ST_ZONE].rem3 < pipe[ST_ZONE].den3, "ratio quotient overflows")

endmodule
`default_nettype wire
